// ===== rtl/lruct_pkg.sv =====
// Shared types and constants for the LRU hit/miss tracker.
package lruct_pkg;

    localparam int ADDR_W           = 32;
    localparam int CNT_W            = 32;
    localparam int CAPACITY_DEFAULT = 64;
    localparam int CAPACITY_MAX     = 8192;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [ADDR_W-1:0] access_address;
    } lookup_beat_t;

    typedef struct packed {
        logic              was_hit;
        logic              evicted_valid;
        logic [ADDR_W-1:0] evicted_address;
        logic [CNT_W-1:0]  hits_so_far;
        logic [CNT_W-1:0]  misses_so_far;
    } result_beat_t;

    // Lookup wave traveling down the cell row.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic              found;
        logic              carry_valid;
        logic [ADDR_W-1:0] carry_addr;
    } wave_t;

endpackage

// ===== rtl/lruct_if.sv =====
// Valid/ready stream interfaces for lookup and result beats.
interface lruct_lookup_if
    import lruct_pkg::*;
    ();
    logic         valid;
    logic         ready;
    lookup_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lruct_result_if
    import lruct_pkg::*;
    ();
    logic         valid;
    logic         ready;
    result_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/lruct_cell.sv =====
// One LRU stack cell: holds an entry, compares it, and passes the wave on.
module lruct_cell
    import lruct_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  wave_t wave_in,
    output wave_t wave_out
);

    logic [ADDR_W-1:0] entry_addr_reg;
    logic              entry_valid_reg;
    logic              wave_valid_reg;
    wave_t             wave_reg;
    wave_t             wave_next;
    logic              take;
    logic              hit;

    assign take = wave_in.valid && !wave_in.found;
    assign hit  = take && entry_valid_reg && (entry_addr_reg == wave_in.addr);

    always_comb
    begin
        wave_next       = wave_in;
        wave_next.found = wave_in.found || hit;
        if (hit)
        begin
            // matched entry is replaced by the carry; nothing moves further down
            wave_next.carry_valid = 1'b0;
        end
        else if (take)
        begin
            wave_next.carry_valid = entry_valid_reg;
            wave_next.carry_addr  = entry_addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
            wave_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            wave_valid_reg <= wave_in.valid;
            if (take)
            begin
                entry_valid_reg <= wave_in.carry_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wave_reg <= wave_next;
            if (take)
            begin
                entry_addr_reg <= wave_in.carry_addr;
            end
        end
    end

    always_comb
    begin
        wave_out       = wave_reg;
        wave_out.valid = wave_valid_reg;
    end

endmodule

// ===== rtl/lruct_tail.sv =====
// End of the cell row: hit/miss counters and the result register.
module lruct_tail
    import lruct_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  wave_t        wave_in,
    input  logic         res_ready,
    output logic         adv,
    output logic         res_valid,
    output result_beat_t res_payload
);

    logic              res_valid_reg;
    logic [CNT_W-1:0]  hit_cnt_reg;
    logic [CNT_W-1:0]  hit_cnt_next;
    logic [CNT_W-1:0]  miss_cnt_reg;
    logic [CNT_W-1:0]  miss_cnt_next;
    logic              was_hit_reg;
    logic              evicted_valid_reg;
    logic [ADDR_W-1:0] evicted_addr_reg;
    logic              evict;

    assign adv   = !res_valid_reg || res_ready;
    assign evict = !wave_in.found && wave_in.carry_valid;

    always_comb
    begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (wave_in.valid)
        begin
            if (wave_in.found)
            begin
                if (hit_cnt_reg != CNT_MAX)
                begin
                    hit_cnt_next = hit_cnt_reg + 1'b1;
                end
            end
            else if (miss_cnt_reg != CNT_MAX)
            begin
                miss_cnt_next = miss_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
        end
        else if (adv)
        begin
            res_valid_reg <= wave_in.valid;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && wave_in.valid)
        begin
            was_hit_reg       <= wave_in.found;
            evicted_valid_reg <= evict;
            evicted_addr_reg  <= evict ? wave_in.carry_addr : '0;
        end
    end

    assign res_valid                   = res_valid_reg;
    assign res_payload.was_hit         = was_hit_reg;
    assign res_payload.evicted_valid   = evicted_valid_reg;
    assign res_payload.evicted_address = evicted_addr_reg;
    assign res_payload.hits_so_far     = hit_cnt_reg;
    assign res_payload.misses_so_far   = miss_cnt_reg;

endmodule

// ===== rtl/lru_cache_hit_miss_tracker.sv =====
// Top level: fully associative LRU directory built as a row of stack cells.
// Each lookup beat reaches the result beat through the CAPACITY cell registers, one per cell,
// and then the result register.
// Throughput: one lookup per cycle; each lookup wave sweeps the cell row one cell a cycle.
// A held result stalls the whole row, and lookup.ready drops with it.
// Reset clears all entry valid flags, in-flight waves and both counters.
module lru_cache_hit_miss_tracker
    import lruct_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lruct_lookup_if.sink          lookup,
    lruct_result_if.source        result
);

    wave_t wave [CAPACITY+1];
    logic  adv;

    assign lookup.ready = adv;

    always_comb
    begin
        wave[0].valid       = lookup.valid;
        wave[0].addr        = lookup.payload.access_address;
        wave[0].found       = 1'b0;
        wave[0].carry_valid = 1'b1;
        wave[0].carry_addr  = lookup.payload.access_address;
    end

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        lruct_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .wave_in  (wave[k]),
            .wave_out (wave[k+1])
        );
    end

    lruct_tail u_tail (
        .clk         (clk),
        .rst_n       (rst_n),
        .wave_in     (wave[CAPACITY]),
        .res_ready   (result.ready),
        .adv         (adv),
        .res_valid   (result.valid),
        .res_payload (result.payload)
    );

endmodule

// ===== rtl/lruct_checker.sv =====
// Port-level checks for the LRU tracker, bound to the top level.
module lruct_checker
    import lruct_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         lookup_ready,
    input logic         res_valid,
    input logic         res_ready,
    input result_beat_t res_payload
);

    logic [CNT_W-1:0] prev_hits_reg;
    logic [CNT_W-1:0] prev_misses_reg;
    logic [CNT_W-1:0] hits_step;
    logic [CNT_W-1:0] misses_step;

    assign hits_step   = (prev_hits_reg == CNT_MAX) ? prev_hits_reg : prev_hits_reg + 1'b1;
    assign misses_step = (prev_misses_reg == CNT_MAX) ? prev_misses_reg
                                                      : prev_misses_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_hits_reg   <= '0;
            prev_misses_reg <= '0;
        end
        else if (res_valid && res_ready)
        begin
            prev_hits_reg   <= res_payload.hits_so_far;
            prev_misses_reg <= res_payload.misses_so_far;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_payload))
        else $error("result beat changed while stalled");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !lookup_ready)
        else $error("lookup accepted while row is stalled");

    a_evict: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_payload.was_hit && res_payload.evicted_valid)
                      && (res_payload.evicted_valid || res_payload.evicted_address == '0))
        else $error("bad eviction report");

    a_hit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && res_payload.was_hit
        |-> res_payload.hits_so_far == hits_step
            && res_payload.misses_so_far == prev_misses_reg)
        else $error("hit count step wrong");

    a_miss_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_payload.was_hit
        |-> res_payload.misses_so_far == misses_step
            && res_payload.hits_so_far == prev_hits_reg)
        else $error("miss count step wrong");

endmodule

bind lru_cache_hit_miss_tracker lruct_checker u_lruct_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .lookup_ready (lookup.ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_payload  (result.payload)
);

// ===== bench/lru_cache_hit_miss_tracker_test.sv =====
// Self-checking bench: LRU tracker driven with random address streams, results checked in order.
module lru_cache_hit_miss_tracker_test
    import lruct_pkg::*;
    ();

    localparam int CAPACITY    = CAPACITY_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 550;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              send_valid = 1'b0;
    logic [ADDR_W-1:0] send_addr  = '0;
    logic              take_ready = 1'b0;
    logic              hold_off   = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int phase_no       = 0;
    int queued         = 0;
    int results_seen   = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    logic [ADDR_W-1:0] pending_lookups [$];
    result_beat_t      expected_results [$];

    // shadow LRU stack, position 0 most recent
    logic [ADDR_W-1:0] lru_order [CAPACITY];
    int                lru_depth  = 0;
    logic [CNT_W-1:0]  hit_total  = '0;
    logic [CNT_W-1:0]  miss_total = '0;

    lruct_lookup_if lookup_ch ();
    lruct_result_if result_ch ();

    assign lookup_ch.valid                  = send_valid;
    assign lookup_ch.payload.access_address = send_addr;
    assign result_ch.ready                  = take_ready;

    lru_cache_hit_miss_tracker #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .lookup (lookup_ch),
        .result (result_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic result_beat_t touch_lru(input logic [ADDR_W-1:0] addr);
        result_beat_t r;
        int           pos;
        int           top;
        int           k;
        r   = '0;
        pos = -1;
        top = 0;
        for (k = 0; k < lru_depth; k++)
        begin
            if (pos < 0 && lru_order[k] == addr)
                pos = k;
        end
        if (pos >= 0)
        begin
            r.was_hit = 1'b1;
            top       = pos;
            if (hit_total != CNT_MAX)
                hit_total++;
        end
        else
        begin
            if (lru_depth == CAPACITY)
            begin
                r.evicted_valid   = 1'b1;
                r.evicted_address = lru_order[CAPACITY-1];
                top               = CAPACITY - 1;
            end
            else
            begin
                top = lru_depth;
                lru_depth++;
            end
            if (miss_total != CNT_MAX)
                miss_total++;
        end
        for (k = top; k > 0; k--)
            lru_order[k] = lru_order[k-1];
        lru_order[0]    = addr;
        r.hits_so_far   = hit_total;
        r.misses_so_far = miss_total;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address(input logic [ADDR_W-1:0] base);
        case ($urandom_range(3))
            0: return base ^ (32'd1 << $urandom_range(31));
            1: return ADDR_W'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_lookup(input logic [ADDR_W-1:0] addr);
        pending_lookups.push_back(addr);
        queued++;
    endtask

    // lookup driver: beat held until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_valid <= 1'b0;
            send_addr  <= '0;
        end
        else if (!send_valid || lookup_ch.ready)
        begin
            if (send_valid)
                expected_results.push_back(touch_lru(send_addr));
            if (pending_lookups.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                send_valid <= 1'b1;
                send_addr  <= pending_lookups.pop_front();
            end
            else
            begin
                send_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : result_check
        result_beat_t want;
        result_beat_t got;
        if (!rst_n)
        begin
            take_ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && take_ready)
            begin
                got = result_ch.payload;
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("result %0d: unexpected beat, hit=%0b hits=%0d misses=%0d",
                                 results_seen, got.was_hit, got.hits_so_far,
                                 got.misses_so_far);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.was_hit !== want.was_hit
                        || got.evicted_valid !== want.evicted_valid
                        || got.evicted_address !== want.evicted_address
                        || got.hits_so_far !== want.hits_so_far
                        || got.misses_so_far !== want.misses_so_far)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("result %0d mismatch:", results_seen);
                            $display("  want hit=%0b ev=%0b evaddr=%h hits=%0d misses=%0d",
                                     want.was_hit, want.evicted_valid, want.evicted_address,
                                     want.hits_so_far, want.misses_so_far);
                            $display("  got  hit=%0b ev=%0b evaddr=%h hits=%0d misses=%0d",
                                     got.was_hit, got.evicted_valid, got.evicted_address,
                                     got.hits_so_far, got.misses_so_far);
                        end
                    end
                end
            end
            take_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // long receiver hold so the cell row fills and lookup.ready drops
    initial
    begin
        wait (phase_no == 2);
        repeat (20) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        logic [ADDR_W-1:0] pool [$];
        logic [ADDR_W-1:0] base;
        int                n;
        int                target;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, hit below the top, repeat on the top, near-equal patterns
        queue_lookup(32'h0000_0000);
        queue_lookup(32'hFFFF_FFFF);
        queue_lookup(32'h0000_0000);
        queue_lookup(32'h0000_0000);
        queue_lookup(32'hFFFF_FFFF);
        queue_lookup(32'h8000_0000);
        queue_lookup(32'h0000_0001);
        queue_lookup(32'hAAAA_AAAA);
        queue_lookup(32'h5555_5555);
        queue_lookup(32'hFFFF_FFFE);
        queue_lookup(32'h7FFF_FFFF);
        queue_lookup(32'h0000_0000);
        queue_lookup(32'h8000_0000);
        queue_lookup(32'h1234_5678);

        for (phase_no = 0; phase_no < 3; phase_no++)
        begin
            send_idle_pct  = (phase_no == 0) ? 36 : (phase_no == 1) ? 53 : 0;
            recv_stall_pct = (phase_no == 0) ? 53 : (phase_no == 1) ? 36 : 0;
            target = queued + PHASE_ITEMS;
            while (queued < target)
            begin
                pool.delete();
                base = $urandom;
                case ($urandom_range(9))
                    0, 1, 2, 3:
                    begin
                        // cyclic scan around capacity: deep hits or eviction on every miss
                        n = $urandom_range(CAPACITY - 2, CAPACITY + 2);
                        repeat (n) pool.push_back(pick_address(base));
                        repeat (2)
                        begin
                            foreach (pool[i])
                                queue_lookup(pool[i]);
                        end
                    end
                    4, 5, 6, 7:
                    begin
                        n = $urandom_range(4, CAPACITY + 16);
                        repeat (n) pool.push_back(pick_address(base));
                        repeat (40) queue_lookup(pool[$urandom_range(n - 1)]);
                    end
                    default:
                    begin
                        repeat (16) queue_lookup(pick_address(base));
                    end
                endcase
            end
            while (pending_lookups.size() != 0 || send_valid || expected_results.size() != 0)
                @(posedge clk);
        end

        repeat (CAPACITY + 20) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
